// ===== rtl/peq_pkg.sv =====
// peq_pkg: shared types and constants for the priority event queue.
// Used by peq_cell and priority_event_queue; no dependencies.
`default_nettype none

package peq_pkg;

    localparam int PRIO_W   = 8;
    localparam int TAG_IN_W = 16;
    localparam int OCC_W    = 5;

    // kind field of an input word
    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_POP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Operation broadcast to every cell for one accepted word
    typedef struct packed {
        logic add;
        logic pop;
    } t_cell_op;

endpackage

`default_nettype wire

// ===== rtl/peq_cell.sv =====
// peq_cell: one slot of the sorted queue; holds an entry and trades it with neighbors.
// Depends on peq_pkg.
`default_nettype none

module peq_cell #(
    parameter int TAG_W = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire peq_pkg::t_cell_op         i_op,
    input  wire logic [peq_pkg::PRIO_W-1:0] i_new_prio,
    input  wire logic [TAG_W-1:0]          i_new_tag,
    input  wire logic                      i_left_valid,
    input  wire logic                      i_left_after,
    input  wire logic [peq_pkg::PRIO_W-1:0] i_left_prio,
    input  wire logic [TAG_W-1:0]          i_left_tag,
    input  wire logic                      i_right_valid,
    input  wire logic [peq_pkg::PRIO_W-1:0] i_right_prio,
    input  wire logic [TAG_W-1:0]          i_right_tag,
    output logic                           o_valid,
    output logic                           o_after,
    output logic [peq_pkg::PRIO_W-1:0]     o_prio,
    output logic [TAG_W-1:0]               o_tag
);

    logic                       r_valid, n_valid;
    logic [peq_pkg::PRIO_W-1:0] r_prio, n_prio;
    logic [TAG_W-1:0]           r_tag, n_tag;
    logic                       after;

    // new entry goes behind this one
    assign after = r_valid && (r_prio >= i_new_prio);

    always_comb begin
        n_valid = r_valid;
        n_prio  = r_prio;
        n_tag   = r_tag;
        if (i_op.add && !after) begin
            if (i_left_after) begin
                n_valid = 1'b1;
                n_prio  = i_new_prio;
                n_tag   = i_new_tag;
            end else begin
                n_valid = i_left_valid;
                n_prio  = i_left_prio;
                n_tag   = i_left_tag;
            end
        end else if (i_op.pop) begin
            n_valid = i_right_valid;
            n_prio  = i_right_prio;
            n_tag   = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_after = after;
    assign o_prio  = r_prio;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

// ===== rtl/priority_event_queue.sv =====
// priority_event_queue: bounded sorted queue of event tags built as a row of cells.
// Depends on peq_pkg and peq_cell.
//
// Each input word either adds (priority, tag) or pops the head entry; every word
// returns one result word with status, popped entry and occupancy. Entries are
// kept sorted in a row of QUEUE_DEPTH cells: higher priority first, equal
// priorities in arrival order. All cells compare against the new priority in
// parallel and shift one place left or right in the same cycle, so a word is
// taken every cycle while the output register can drain; the result appears in the
// cycle after acceptance. Add on a full queue drops the entry, pop on an empty
// queue changes nothing.
`default_nettype none

module priority_event_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // priority_req[7:0], event_tag[23:8]
    input  wire logic        s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // out_priority[7:0], out_tag[23:8],
                                            // occupancy[28:24], zero pad
    output logic [1:0]       m_axis_tuser   // status
);

    localparam int TAG_W = (TAG_BITS < peq_pkg::TAG_IN_W) ? TAG_BITS : peq_pkg::TAG_IN_W;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                       in_fire;
    logic                       full, empty;
    logic [peq_pkg::PRIO_W-1:0] new_prio;
    logic [TAG_W-1:0]           new_tag;
    peq_pkg::t_cell_op          op;

    logic                       c_valid [QUEUE_DEPTH];
    logic                       c_after [QUEUE_DEPTH];
    logic [peq_pkg::PRIO_W-1:0] c_prio  [QUEUE_DEPTH];
    logic [TAG_W-1:0]           c_tag   [QUEUE_DEPTH];

    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_out_valid;
    peq_pkg::t_status           r_status, n_status;
    logic [peq_pkg::PRIO_W-1:0] r_out_prio, n_out_prio;
    logic [TAG_W-1:0]           r_out_tag, n_out_tag;
    logic [peq_pkg::OCC_W-1:0]  r_occ;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign new_prio      = s_axis_tdata[7:0];
    assign new_tag       = s_axis_tdata[8 +: TAG_W];
    assign full          = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty         = (r_count == '0);

    assign op.add = in_fire && !s_axis_tuser && !full;
    assign op.pop = in_fire &&  s_axis_tuser && !empty;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                       left_valid, left_after, right_valid;
            logic [peq_pkg::PRIO_W-1:0] left_prio, right_prio;
            logic [TAG_W-1:0]           left_tag, right_tag;

            if (g == 0) begin : g_head
                assign left_valid = 1'b0;
                assign left_after = 1'b1;
                assign left_prio  = '0;
                assign left_tag   = '0;
            end else begin : g_body
                assign left_valid = c_valid[g-1];
                assign left_after = c_after[g-1];
                assign left_prio  = c_prio[g-1];
                assign left_tag   = c_tag[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign right_valid = 1'b0;
                assign right_prio  = '0;
                assign right_tag   = '0;
            end else begin : g_mid
                assign right_valid = c_valid[g+1];
                assign right_prio  = c_prio[g+1];
                assign right_tag   = c_tag[g+1];
            end

            peq_cell #(
                .TAG_W (TAG_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_op          (op),
                .i_new_prio    (new_prio),
                .i_new_tag     (new_tag),
                .i_left_valid  (left_valid),
                .i_left_after  (left_after),
                .i_left_prio   (left_prio),
                .i_left_tag    (left_tag),
                .i_right_valid (right_valid),
                .i_right_prio  (right_prio),
                .i_right_tag   (right_tag),
                .o_valid       (c_valid[g]),
                .o_after       (c_after[g]),
                .o_prio        (c_prio[g]),
                .o_tag         (c_tag[g])
            );
        end
    endgenerate

    always_comb begin
        n_count    = r_count;
        n_status   = peq_pkg::ST_OK;
        n_out_prio = '0;
        n_out_tag  = '0;
        if (!s_axis_tuser) begin
            if (full) begin
                n_status = peq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = peq_pkg::ST_EMPTY;
            end else begin
                n_count    = r_count - CNT_W'(1);
                n_out_prio = c_prio[0];
                n_out_tag  = c_tag[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_fire) begin
            r_status   <= n_status;
            r_out_prio <= n_out_prio;
            r_out_tag  <= n_out_tag;
            r_occ      <= peq_pkg::OCC_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'b000, r_occ, 16'(r_out_tag), r_out_prio};

endmodule

`default_nettype wire
